// ===== hdl/gradient_pixel_color_lookup_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the gradient pixel colour lookup
// Shared implication forms used by the modules that check their own logic.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_PIXEL_COLOR_LOOKUP_ASSERT_SVH
`define GRADIENT_PIXEL_COLOR_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GPCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpcl assertion failed");

// Next-cycle implication, disabled while in reset.
`define GPCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpcl assertion failed");

`endif

// ===== hdl/gpcl_pkg.sv =====
// ---------------------------------------------------------------------------
// gpcl_pkg
// Types, constants and tables shared by the gradient lookup modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gpcl_pkg;

    localparam int COORD_W          = 16;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int TWO_PI_Q16       = 411774;
    localparam int HALF_PI_Q16      = 102944;

    localparam logic [2:0] REG_START_X    = 3'd0;
    localparam logic [2:0] REG_START_Y    = 3'd1;
    localparam logic [2:0] REG_END_X      = 3'd2;
    localparam logic [2:0] REG_END_Y      = 3'd3;
    localparam logic [2:0] REG_STYLE      = 3'd4;
    localparam logic [2:0] REG_TABLE_SIZE = 3'd5;

    localparam logic [1:0] STYLE_LINEAR  = 2'd0;
    localparam logic [1:0] STYLE_CIRCLE  = 2'd1;
    localparam logic [1:0] STYLE_RADIAL  = 2'd2;
    localparam logic [1:0] STYLE_REFLECT = 2'd3;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] pix_x;
        logic signed [COORD_W-1:0] pix_y;
        logic [7:0]                entry_index;
        logic [23:0]               write_color;
    } in_t;

    typedef struct packed {
        logic [7:0]  color_index;
        logic [23:0] pixel_color;
        logic        degenerate;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [1:0]                style;
        logic [8:0]                table_size;
    } cfg_t;

    // Word held in the queue between front and back: already classified,
    // pixel offsets already taken relative to the start point.
    typedef struct packed {
        logic                     is_write;
        logic signed [DIFF_W-1:0] px;
        logic signed [DIFF_W-1:0] py;
        logic [7:0]               entry_index;
        logic [23:0]              write_color;
    } qitem_t;

    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gpcl_front.sv =====
// ---------------------------------------------------------------------------
// gpcl_front
// Accepts words, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gpcl_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gpcl_pkg::in_t                     item,
    input  logic                              push,
    output logic                              full,
    input  logic signed [gpcl_pkg::COORD_W-1:0] start_x,
    input  logic signed [gpcl_pkg::COORD_W-1:0] start_y,
    output logic                              q_valid,
    output gpcl_pkg::qitem_t                  q_item,
    input  logic                              q_pop
);
    import gpcl_pkg::*;

    `include "gradient_pixel_color_lookup_assert.svh"

    qitem_t     fifo_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       accept;
    qitem_t     cls;

    assign full    = (count_reg == 2'd2);
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        cls.is_write    = (item.req_type == REQ_WRITE);
        cls.px          = DIFF_W'(item.pix_x) - DIFF_W'(start_x);
        cls.py          = DIFF_W'(item.pix_y) - DIFF_W'(start_y);
        cls.entry_index = item.entry_index;
        cls.write_color = item.write_color;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (accept && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!accept && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `GPCL_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= 2'd2)
    `GPCL_ASSERT_NEXT(a_full_holds, clk, rst_n, (full && !q_pop), count_reg == 2'd2)
    `GPCL_ASSERT_NEXT(a_count_up, clk, rst_n, (accept && !q_pop), count_reg == $past(count_reg) + 2'd1)

endmodule

`default_nettype wire

// ===== hdl/gpcl_back.sv =====
// ---------------------------------------------------------------------------
// gpcl_back
// Sequencer that executes table writes and computes pixel table positions.
// ---------------------------------------------------------------------------
`default_nettype none

module gpcl_back #(
    parameter int TABLE_DEPTH  = gpcl_pkg::DEF_TABLE_DEPTH,
    parameter int CORDIC_STEPS = gpcl_pkg::DEF_CORDIC_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gpcl_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  gpcl_pkg::qitem_t  q_item,
    output logic              q_pop,
    output gpcl_pkg::out_t    result,
    output logic              empty,
    input  logic              pop
);
    import gpcl_pkg::*;

    `include "gradient_pixel_color_lookup_assert.svh"

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW     = (AW > 1) ? $clog2(AW) : 1;
    localparam int SZW    = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int PW     = 2 * DIFF_W;
    localparam int LW     = PW;
    localparam int DTW    = PW + 1;
    localparam int NW     = DTW + AW;
    localparam int SQW    = 2 * AW;
    localparam int RW     = SQW + LW;
    localparam int XW     = 44;
    localparam int ZW     = 21;
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam logic [XW-1:0] LIM_HI = XW'(1) << 40;
    localparam logic [XW-1:0] LIM_LO = XW'(1) << 32;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_NUM  = 4'd3;
    localparam logic [3:0] S_DCHK = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_RHS1 = 4'd6;
    localparam logic [3:0] S_RHS2 = 4'd7;
    localparam logic [3:0] S_CSQ  = 4'd8;
    localparam logic [3:0] S_CCMP = 4'd9;
    localparam logic [3:0] S_NORM = 4'd10;
    localparam logic [3:0] S_CORD = 4'd11;
    localparam logic [3:0] S_ANG  = 4'd12;
    localparam logic [3:0] S_LOOK = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg;
    out_t        result_reg;

    logic [23:0] mem [TABLE_DEPTH];
    logic [23:0] rdata_reg;

    logic signed [DIFF_W-1:0] px_reg, py_reg;
    logic [3:0]               cnt_reg;
    logic signed [PW-1:0]     prod_reg;
    logic [LW-1:0]            len2_reg, p2_reg;
    logic signed [DTW-1:0]    dot_reg, crs_reg;
    logic [AW-1:0]            top_reg, idx_reg, trial_reg;
    logic                     deg_reg;
    logic [DTW-1:0]           numsrc_reg;
    logic [LW-1:0]            den_reg;
    logic [NW-1:0]            num_reg, rem_reg;
    logic [AW-1:0]            quo_reg;
    logic [BW-1:0]            bit_reg;
    logic [SQW-1:0]           sq_reg;
    logic [RW-1:0]            rhs_reg;
    logic signed [XW-1:0]     cx_reg, cy_reg;
    logic signed [ZW-1:0]     z_reg;
    logic [4:0]               i_reg;

    // Combinational helpers
    logic signed [DIFF_W-1:0] dx_c, dy_c, ma, mb;
    logic [SZW-1:0]           ts_c, size_c;
    logic [AW-1:0]            top_c;
    logic [AW+7:0]            entry_ext;
    logic                     entry_ok, mem_we;
    logic                     deg_c, sat_c, out_load;
    logic [DTW-1:0]           dot_mag;
    logic [NW-1:0]            dsh_c;
    logic                     dfit_c;
    logic [AW-1:0]            quo_c, trial_c;
    logic [RW-1:0]            tl_c;
    logic                     cok_c;
    logic [XW-1:0]            mx_c, my_c, m_c;
    logic                     norm_done_c;
    logic signed [XW-1:0]     shx_c, shy_c;
    logic signed [ZW-1:0]     atan_z, ang_c;

    assign dx_c = DIFF_W'(cfg.end_x) - DIFF_W'(cfg.start_x);
    assign dy_c = DIFF_W'(cfg.end_y) - DIFF_W'(cfg.start_y);

    always_comb
    begin
        ts_c = SZW'(cfg.table_size);
        if (ts_c < SZW'(2))
        begin
            size_c = SZW'(2);
        end
        else if (ts_c > SZW'(TABLE_DEPTH))
        begin
            size_c = SZW'(TABLE_DEPTH);
        end
        else
        begin
            size_c = ts_c;
        end
    end
    assign top_c = AW'(size_c - SZW'(1));

    assign entry_ext = (AW + 8)'(q_item.entry_index);
    assign entry_ok  = (entry_ext < (AW + 8)'(TABLE_DEPTH));
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign mem_we    = q_pop && q_item.is_write && entry_ok;

    // One shared multiplier walks through the eight products.
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin ma = dx_c;   mb = dx_c; end
            3'd1:    begin ma = dy_c;   mb = dy_c; end
            3'd2:    begin ma = px_reg; mb = px_reg; end
            3'd3:    begin ma = py_reg; mb = py_reg; end
            3'd4:    begin ma = px_reg; mb = dx_c; end
            3'd5:    begin ma = py_reg; mb = dy_c; end
            3'd6:    begin ma = px_reg; mb = dy_c; end
            default: begin ma = py_reg; mb = dx_c; end
        endcase
    end

    assign deg_c    = (len2_reg == '0) || (p2_reg == '0);
    assign dot_mag  = dot_reg[DTW-1] ? DTW'(-dot_reg) : DTW'(dot_reg);
    assign sat_c    = (num_reg >= (NW'(den_reg) << AW));
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || pop);

    assign dsh_c  = NW'(den_reg) << bit_reg;
    assign dfit_c = (rem_reg >= dsh_c);
    always_comb
    begin
        quo_c = quo_reg;
        if (dfit_c)
        begin
            quo_c[bit_reg] = 1'b1;
        end
    end

    assign trial_c = idx_reg | (AW'(1) << bit_reg);
    assign tl_c    = sq_reg * len2_reg;
    assign cok_c   = (trial_reg <= top_reg) && (tl_c <= rhs_reg);

    assign mx_c        = cx_reg[XW-1] ? XW'(-cx_reg) : XW'(cx_reg);
    assign my_c        = cy_reg[XW-1] ? XW'(-cy_reg) : XW'(cy_reg);
    assign m_c         = (mx_c > my_c) ? mx_c : my_c;
    assign norm_done_c = (m_c >= LIM_HI) || (m_c == '0);

    assign shx_c  = cx_reg >>> i_reg;
    assign shy_c  = cy_reg >>> i_reg;
    assign atan_z = signed'(ZW'(atan_q16(i_reg)));
    assign ang_c  = z_reg + (crs_reg[DTW-1] ? ZW'(TWO_PI_Q16) : ZW'(0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !q_item.is_write)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == 4'd8)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (deg_c)
                begin
                    state_next = S_LOOK;
                end
                else if (cfg.style == STYLE_CIRCLE)
                begin
                    state_next = S_RHS1;
                end
                else if (cfg.style == STYLE_RADIAL)
                begin
                    state_next = S_NORM;
                end
                else if (cfg.style == STYLE_LINEAR && dot_reg[DTW-1])
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:  state_next = S_DCHK;
            S_DCHK: state_next = sat_c ? S_LOOK : S_DIV;
            S_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_LOOK;
                end
            end
            S_RHS1: state_next = S_RHS2;
            S_RHS2: state_next = S_CSQ;
            S_CSQ:  state_next = S_CCMP;
            S_CCMP: state_next = (bit_reg == '0) ? S_LOOK : S_CSQ;
            S_NORM:
            begin
                if (norm_done_c)
                begin
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                if (i_reg == 5'(NSTEPS - 1))
                begin
                    state_next = S_ANG;
                end
            end
            S_ANG:  state_next = S_NUM;
            S_LOOK: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[entry_ext[AW-1:0]] <= q_item.write_color;
        end
        if (state_reg == S_LOOK)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg <= 4'd0;
                px_reg  <= q_item.px;
                py_reg  <= q_item.py;
                top_reg <= top_c;
            end
            S_MUL:
            begin
                cnt_reg  <= cnt_reg + 4'd1;
                prod_reg <= ma * mb;
                // Accumulate the product registered in the previous cycle.
                if (cnt_reg != 4'd0)
                begin
                    case (cnt_reg[2:0] - 3'd1)
                        3'd0:    len2_reg <= LW'(prod_reg);
                        3'd1:    len2_reg <= len2_reg + LW'(prod_reg);
                        3'd2:    p2_reg   <= LW'(prod_reg);
                        3'd3:    p2_reg   <= p2_reg + LW'(prod_reg);
                        3'd4:    dot_reg  <= DTW'(prod_reg);
                        3'd5:    dot_reg  <= dot_reg + DTW'(prod_reg);
                        3'd6:    crs_reg  <= DTW'(prod_reg);
                        default: crs_reg  <= crs_reg - DTW'(prod_reg);
                    endcase
                end
            end
            S_DEC:
            begin
                deg_reg    <= deg_c;
                idx_reg    <= '0;
                numsrc_reg <= dot_mag;
                den_reg    <= len2_reg;
                cx_reg     <= XW'(dot_reg);
                cy_reg     <= XW'(crs_reg);
            end
            S_NUM:
            begin
                num_reg <= numsrc_reg * top_reg;
            end
            S_DCHK:
            begin
                rem_reg <= num_reg;
                quo_reg <= '0;
                bit_reg <= BW'(AW - 1);
                if (sat_c)
                begin
                    idx_reg <= top_reg;
                end
            end
            S_DIV:
            begin
                if (dfit_c)
                begin
                    rem_reg <= rem_reg - dsh_c;
                end
                quo_reg <= quo_c;
                bit_reg <= bit_reg - BW'(1);
                if (bit_reg == '0)
                begin
                    idx_reg <= (quo_c > top_reg) ? top_reg : quo_c;
                end
            end
            S_RHS1:
            begin
                sq_reg <= top_reg * top_reg;
            end
            S_RHS2:
            begin
                rhs_reg <= sq_reg * p2_reg;
                bit_reg <= BW'(AW - 1);
            end
            S_CSQ:
            begin
                trial_reg <= trial_c;
                sq_reg    <= trial_c * trial_c;
            end
            S_CCMP:
            begin
                if (cok_c)
                begin
                    idx_reg <= trial_reg;
                end
                bit_reg <= bit_reg - BW'(1);
            end
            S_NORM:
            begin
                i_reg <= 5'd0;
                if (norm_done_c)
                begin
                    // Fold the left half-plane onto the right one.
                    if (cx_reg[XW-1])
                    begin
                        if (!cy_reg[XW-1])
                        begin
                            cx_reg <= cy_reg;
                            cy_reg <= -cx_reg;
                            z_reg  <= ZW'(HALF_PI_Q16);
                        end
                        else
                        begin
                            cx_reg <= -cy_reg;
                            cy_reg <= cx_reg;
                            z_reg  <= -ZW'(HALF_PI_Q16);
                        end
                    end
                    else
                    begin
                        z_reg <= '0;
                    end
                end
                else if (m_c < LIM_LO)
                begin
                    cx_reg <= cx_reg <<< 8;
                    cy_reg <= cy_reg <<< 8;
                end
                else
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            S_CORD:
            begin
                i_reg <= i_reg + 5'd1;
                if (!cy_reg[XW-1] && (cy_reg != '0))
                begin
                    cx_reg <= cx_reg + shy_c;
                    cy_reg <= cy_reg - shx_c;
                    z_reg  <= z_reg + atan_z;
                end
                else
                begin
                    cx_reg <= cx_reg - shy_c;
                    cy_reg <= cy_reg + shx_c;
                    z_reg  <= z_reg - atan_z;
                end
            end
            S_ANG:
            begin
                numsrc_reg <= ang_c[ZW-1] ? DTW'(0) : DTW'(unsigned'(ang_c));
                den_reg    <= LW'(TWO_PI_Q16);
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    result_reg.color_index <= 8'(idx_reg);
                    result_reg.pixel_color <= rdata_reg;
                    result_reg.degenerate  <= deg_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

    `GPCL_ASSERT_IMPL(a_idx_in_range, clk, rst_n, (state_reg == S_LOOK), idx_reg <= top_reg)
    `GPCL_ASSERT_NEXT(a_out_loaded, clk, rst_n, out_load, out_valid_reg && (state_reg == S_IDLE))
    `GPCL_ASSERT_IMPL(a_cordic_bound, clk, rst_n, (state_reg == S_CORD), i_reg < 5'(NSTEPS))

endmodule

`default_nettype wire

// ===== hdl/gradient_pixel_color_lookup.sv =====
// Flow: a table write is done as it leaves the queue; a pixel word runs from queue head
// to result through the shared multiplier, then a divide (linear, reflect), a bitwise
// root search (circle) or CORDIC and divide (radial), then the table read.
// Throughput: one pixel at a time, set by the shared multiplier, divider and CORDIC loop.
// Reset: registers return to their listed values, both queues empty; the table is
// undefined until written.
// ---------------------------------------------------------------------------
// gradient_pixel_color_lookup
// Top level: configuration registers, classifying front end and compute back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gradient_pixel_color_lookup #(
    parameter int TABLE_DEPTH  = gpcl_pkg::DEF_TABLE_DEPTH,
    parameter int CORDIC_STEPS = gpcl_pkg::DEF_CORDIC_STEPS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [2:0]     wr_index,
    input  logic [15:0]    wr_data,
    input  gpcl_pkg::in_t  item,
    input  logic           push,
    output logic           full,
    output gpcl_pkg::out_t result,
    output logic           empty,
    input  logic           pop
);
    import gpcl_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid;
    logic   q_pop;
    qitem_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x    <= '0;
            cfg_reg.start_y    <= '0;
            cfg_reg.end_x      <= '0;
            cfg_reg.end_y      <= '0;
            cfg_reg.style      <= STYLE_LINEAR;
            cfg_reg.table_size <= 9'd256;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_START_X:    cfg_reg.start_x    <= wr_data;
                REG_START_Y:    cfg_reg.start_y    <= wr_data;
                REG_END_X:      cfg_reg.end_x      <= wr_data;
                REG_END_Y:      cfg_reg.end_y      <= wr_data;
                REG_STYLE:      cfg_reg.style      <= wr_data[1:0];
                REG_TABLE_SIZE: cfg_reg.table_size <= wr_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    gpcl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .start_x (cfg_reg.start_x),
        .start_y (cfg_reg.start_y),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    gpcl_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
